@@ sv/llrb_pkg.sv @@
// ----------------------------------------------------------------------------
// llrb_pkg
// Shared constants and types for the last-lines ring buffer.
// ----------------------------------------------------------------------------
package llrb_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int LINE_CHARS = 4095;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int POS_W  = $clog2(LINE_CHARS + 1);
    localparam int LEN_W  = $clog2(LINE_CHARS + 2);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W = SLOT_W + POS_W;
    localparam int LC_W   = 5;
    localparam int DATA_W = 8;

    localparam int PADDR_W = 3;
    localparam logic REG_LINE_COUNT = 1'b0;

    localparam logic [DATA_W-1:0] NEWLINE          = 8'd10;
    localparam logic [LC_W-1:0]   LINE_COUNT_RESET = 5'd10;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              too_long;
    } result_t;

    typedef struct packed {
        logic            wr;
        logic [LC_W-1:0] line_count;
    } cfg_t;

endpackage

@@ sv/llrb_store.sv @@
// ----------------------------------------------------------------------------
// llrb_store
// Single-port synchronous RAM with a registered read, holding the line bytes.
// ----------------------------------------------------------------------------
module llrb_store #(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ sv/llrb_out_buf.sv @@
// ----------------------------------------------------------------------------
// llrb_out_buf
// Two-entry result queue that decouples the control unit from the output.
// ----------------------------------------------------------------------------
module llrb_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  llrb_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output llrb_pkg::result_t out_data
);

    import llrb_pkg::*;

    result_t    q_reg [2];
    logic [1:0] count_reg;
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ sv/llrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// llrb_ctrl
// Ring control: stores pushed bytes, closes line slots and walks the drain.
// ----------------------------------------------------------------------------
module llrb_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  llrb_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_mode,
    input  logic [llrb_pkg::DATA_W-1:0]  in_byte,
    output logic                         res_valid,
    input  logic                         res_ready,
    output llrb_pkg::result_t            res,
    output logic                         mem_en,
    output logic                         mem_we,
    output logic [llrb_pkg::ADDR_W-1:0]  mem_addr,
    output logic [llrb_pkg::DATA_W-1:0]  mem_wdata,
    input  logic [llrb_pkg::DATA_W-1:0]  mem_rdata
);

    import llrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK_FIRST,
        ST_SEEK_LAST
    } state_t;

    state_t             state_reg,    state_next;
    logic [SLOT_W-1:0]  ws_reg,       ws_next;
    logic [LEN_W-1:0]   ci_reg,       ci_next;
    logic               skip_reg,     skip_next;
    logic               draining_reg, draining_next;
    logic [SLOT_W-1:0]  ds_reg,       ds_next;
    logic [CNT_W-1:0]   dc_reg,       dc_next;
    logic [LEN_W-1:0]   dch_reg,      dch_next;
    logic               too_long_reg, too_long_next;

    logic [LEN_W-1:0]   slot_len_reg [MAX_SLOTS];
    logic               len_we;
    logic               len_clr;
    logic [LEN_W-1:0]   len_wdata;

    logic [CNT_W-1:0]   kept;
    logic [SLOT_W-1:0]  ws_adv;
    logic [SLOT_W-1:0]  ds_adv;
    logic [LEN_W-1:0]   cur_len;
    logic               in_accept;
    logic               closing;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [CNT_W-1:0]  n);
        logic [CNT_W-1:0] inc;
        inc = CNT_W'(s) + CNT_W'(1);
        return (inc >= n) ? '0 : inc[SLOT_W-1:0];
    endfunction

    assign kept      = (cfg.line_count > LC_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                            : CNT_W'(cfg.line_count);
    assign ws_adv    = next_slot(ws_reg, kept);
    assign ds_adv    = next_slot(ds_reg, kept);
    assign cur_len   = slot_len_reg[ds_reg];
    assign in_ready  = (state_reg == ST_IDLE) && res_ready;
    assign in_accept = in_valid && in_ready;
    assign closing   = (ci_reg != '0) || skip_reg;

    always_comb
    begin
        state_next    = state_reg;
        ws_next       = ws_reg;
        ci_next       = ci_reg;
        skip_next     = skip_reg;
        draining_next = draining_reg;
        ds_next       = ds_reg;
        dc_next       = dc_reg;
        dch_next      = dch_reg;
        too_long_next = too_long_reg;
        len_we        = 1'b0;
        len_clr       = 1'b0;
        len_wdata     = ci_reg;
        mem_en        = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = {ds_reg, dch_reg[POS_W-1:0]};
        mem_wdata     = in_byte;
        res_valid     = 1'b0;
        res.valid     = 1'b0;
        res.data      = '0;
        res.last      = 1'b0;
        res.too_long  = too_long_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (kept == '0)
                    begin
                        res_valid = 1'b1;
                    end
                    else if (!in_mode)
                    begin
                        res_valid = 1'b1;
                        if (!draining_reg)
                        begin
                            mem_addr = {ws_reg, ci_reg[POS_W-1:0]};
                            if (in_byte == NEWLINE)
                            begin
                                mem_en    = 1'b1;
                                mem_we    = 1'b1;
                                len_we    = 1'b1;
                                len_wdata = ci_reg + LEN_W'(1);
                                ci_next   = '0;
                                skip_next = 1'b0;
                                ws_next   = ws_adv;
                            end
                            else if (skip_reg)
                            begin
                                skip_next = 1'b1;
                            end
                            else if (ci_reg >= LEN_W'(LINE_CHARS))
                            begin
                                too_long_next = 1'b1;
                                skip_next     = 1'b1;
                            end
                            else
                            begin
                                mem_en  = 1'b1;
                                mem_we  = 1'b1;
                                ci_next = ci_reg + LEN_W'(1);
                            end
                        end
                        res.too_long = too_long_next;
                    end
                    else if (draining_reg)
                    begin
                        mem_en     = 1'b1;
                        dch_next   = dch_reg + LEN_W'(1);
                        state_next = ST_SEEK_LAST;
                    end
                    else
                    begin
                        if (closing)
                        begin
                            len_we    = 1'b1;
                            ci_next   = '0;
                            skip_next = 1'b0;
                            ws_next   = ws_adv;
                        end
                        draining_next = 1'b1;
                        ds_next       = closing ? ws_adv : ws_reg;
                        dc_next       = '0;
                        dch_next      = '0;
                        state_next    = ST_SEEK_FIRST;
                    end
                end
            end
            ST_SEEK_FIRST:
            begin
                if (dc_reg >= kept)
                begin
                    if (res_ready)
                    begin
                        res_valid  = 1'b1;
                        len_clr    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (dch_reg >= cur_len)
                begin
                    ds_next  = ds_adv;
                    dc_next  = dc_reg + CNT_W'(1);
                    dch_next = '0;
                end
                else
                begin
                    mem_en     = 1'b1;
                    dch_next   = dch_reg + LEN_W'(1);
                    state_next = ST_SEEK_LAST;
                end
            end
            ST_SEEK_LAST:
            begin
                if (dc_reg >= kept)
                begin
                    if (res_ready)
                    begin
                        res_valid  = 1'b1;
                        res.valid  = 1'b1;
                        res.data   = mem_rdata;
                        res.last   = 1'b1;
                        len_clr    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (dch_reg >= cur_len)
                begin
                    ds_next  = ds_adv;
                    dc_next  = dc_reg + CNT_W'(1);
                    dch_next = '0;
                end
                else if (res_ready)
                begin
                    res_valid  = 1'b1;
                    res.valid  = 1'b1;
                    res.data   = mem_rdata;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg.wr)
        begin
            len_clr = 1'b1;
        end

        if (len_clr)
        begin
            ws_next       = '0;
            ci_next       = '0;
            skip_next     = 1'b0;
            draining_next = 1'b0;
            ds_next       = '0;
            dc_next       = '0;
            dch_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ws_reg       <= '0;
            ci_reg       <= '0;
            skip_reg     <= 1'b0;
            draining_reg <= 1'b0;
            ds_reg       <= '0;
            dc_reg       <= '0;
            dch_reg      <= '0;
            too_long_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ws_reg       <= ws_next;
            ci_reg       <= ci_next;
            skip_reg     <= skip_next;
            draining_reg <= draining_next;
            ds_reg       <= ds_next;
            dc_reg       <= dc_next;
            dch_reg      <= dch_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                slot_len_reg[i] <= '0;
            end
        end
        else if (len_clr)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                slot_len_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            slot_len_reg[ws_reg] <= len_wdata;
        end
    end

endmodule

@@ sv/last_lines_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// last_lines_ring_buffer
// Push: one transfer per cycle while no drain step is pending and the output
// queue has room; the result is registered in the output queue.
// Pull: the drain walk over the slot lengths passes empty or finished slots
// and reads each byte through the store's registered read port.
// Reset clears the ring control and slot lengths and sets line_count to ten.
// ----------------------------------------------------------------------------
module last_lines_ring_buffer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [llrb_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] in_byte
    input  logic                         s_tuser,  // [0] mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,  // [7:0] out_byte, [8] line_too_long
    output logic                         m_tlast,  // out_last
    output logic                         m_tuser   // [0] out_valid
);

    import llrb_pkg::*;

    logic [LC_W-1:0]   line_count_reg;
    cfg_t              cfg;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    result_t           out_res;
    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    assign pready         = 1'b1;
    assign cfg.wr         = psel && penable && pwrite && pready
                            && (paddr[2] == REG_LINE_COUNT);
    assign cfg.line_count = line_count_reg;
    assign prdata         = (paddr[2] == REG_LINE_COUNT) ? 32'(line_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= LINE_COUNT_RESET;
        end
        else if (cfg.wr)
        begin
            line_count_reg <= pwdata[LC_W-1:0];
        end
    end

    llrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    llrb_store #(
        .AW (ADDR_W),
        .DW (DATA_W)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    llrb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'b0, out_res.too_long, out_res.data};
    assign m_tlast = out_res.last;
    assign m_tuser = out_res.valid;

endmodule
